>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Assertion shorthands for the tape record deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that must also hold during reset.
`define TRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Types and constants shared by the tape record deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package trd_pkg;

  localparam int unsigned LEN_W      = 25;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [FIELD_W-1:0] EOM_MARK        = 32'hFFFF_FFFF;
  localparam logic [LEN_W-1:0]   MAX_BYTES_RESET = 25'd1048576;

  // Register index taken from the word address of the configuration port.
  localparam logic REG_MAX_RECORD_BYTES = 1'b0;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_PAD,
    PH_TRAILER,
    PH_HALTED
  } phase_t;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_MARK     = 3'd2,
    KIND_EOM      = 3'd3,
    KIND_LONG     = 3'd4,
    KIND_MISMATCH = 3'd5,
    KIND_TRUNC    = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data_byte;
    logic             last_of_record;
    logic [LEN_W-1:0] record_length;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/trd_cfg.sv
// ----------------------------------------------------------------------------
// trd_cfg
// APB-style configuration register holding the maximum record length.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [trd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [trd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [trd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output logic      [trd_pkg::LEN_W-1:0]         max_bytes
);
  import trd_pkg::*;

  logic [LEN_W-1:0] max_bytes_r;
  logic             reg_sel;
  logic             wr_en;

  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_MAX_RECORD_BYTES);
  assign wr_en   = psel && penable && pwrite && reg_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= MAX_BYTES_RESET;
    end else if (wr_en) begin
      max_bytes_r <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, max_bytes_r};
    end
  end

  assign pready    = 1'b1;
  assign max_bytes = max_bytes_r;

endmodule

`default_nettype wire

>>> rtl/trd_in_reg.sv
// ----------------------------------------------------------------------------
// trd_in_reg
// Input register that captures one stream beat for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire trd_pkg::item_t  in_item,
  input  wire logic            advance,
  output logic                 item_valid,
  output trd_pkg::item_t       item
);
  import trd_pkg::*;

  logic  valid_r;
  item_t item_r;

  // A held beat that the parser cannot consume this cycle blocks the input.
  assign in_stall = valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

>>> rtl/trd_parse.sv
// ----------------------------------------------------------------------------
// trd_parse
// Record framing state machine: header, payload, pad and trailer handling.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module trd_parse (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       item_valid,
  input  wire trd_pkg::item_t             item,
  input  wire logic                       advance,
  input  wire logic [trd_pkg::LEN_W-1:0]  max_bytes,
  output logic                            res_valid,
  output trd_pkg::result_t                res
);
  import trd_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [1:0]         count_r, count_nxt;
  logic [FIELD_W-1:0] leading_r, leading_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [FIELD_W-1:0] trail_r, trail_nxt;

  logic               fire;
  logic               field_done;
  logic [FIELD_W-1:0] leading_acc;
  logic [FIELD_W-1:0] trail_acc;
  logic [LEN_W-1:0]   rem_dec;
  logic               rec_last;
  logic               too_long;

  assign fire       = item_valid && advance;
  assign field_done = (count_r == 2'd3);

  // Little-endian assembly; a header restarts from zero on its first byte.
  always_comb begin
    leading_acc = (count_r == 2'd0) ? '0 : leading_r;
    leading_acc[{count_r, 3'b000} +: 8] = item.byte_value;
    trail_acc = trail_r;
    trail_acc[{count_r, 3'b000} +: 8] = item.byte_value;
  end

  assign rem_dec  = (rem_r != '0) ? (rem_r - {{(LEN_W-1){1'b0}}, 1'b1}) : rem_r;
  assign rec_last = (rem_dec == '0);
  assign too_long = (leading_acc > {{(FIELD_W-LEN_W){1'b0}}, max_bytes});

  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (item.end_of_input) begin
            phase_nxt = PH_HALTED;
          end else if (field_done) begin
            priority if (leading_acc == EOM_MARK) begin
              phase_nxt = PH_HALTED;
            end else if (leading_acc == '0) begin
              phase_nxt = PH_HEADER;
            end else if (too_long) begin
              phase_nxt = PH_HALTED;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (item.end_of_input) begin
            phase_nxt = PH_HALTED;
          end else if (rec_last) begin
            phase_nxt = leading_r[0] ? PH_PAD : PH_TRAILER;
          end
        end
        PH_PAD: begin
          phase_nxt = item.end_of_input ? PH_HALTED : PH_TRAILER;
        end
        PH_TRAILER: begin
          if (item.end_of_input) begin
            phase_nxt = PH_HALTED;
          end else if (field_done) begin
            phase_nxt = (trail_acc == leading_r) ? PH_HEADER : PH_HALTED;
          end
        end
        PH_HALTED: begin
          phase_nxt = PH_HALTED;
        end
        default: begin
          phase_nxt = PH_HALTED;
        end
      endcase
    end
  end

  always_comb begin
    count_nxt   = count_r;
    leading_nxt = leading_r;
    rem_nxt     = rem_r;
    trail_nxt   = trail_r;
    res_valid   = 1'b0;
    res         = '{kind: KIND_DATA, data_byte: 8'd0, last_of_record: 1'b0,
                    record_length: '0};
    if (fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (item.end_of_input) begin
            res_valid = 1'b1;
            res.kind  = KIND_EOM;
          end else begin
            leading_nxt = leading_acc;
            count_nxt   = count_r + 2'd1;
            if (field_done) begin
              priority if (leading_acc == EOM_MARK) begin
                res_valid = 1'b1;
                res.kind  = KIND_EOM;
              end else if (leading_acc == '0) begin
                res_valid = 1'b1;
                res.kind  = KIND_MARK;
              end else if (too_long) begin
                res_valid = 1'b1;
                res.kind  = KIND_LONG;
              end else begin
                rem_nxt = leading_acc[LEN_W-1:0];
              end
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid = 1'b1;
          if (item.end_of_input) begin
            res.kind = KIND_TRUNC;
          end else begin
            rem_nxt            = rem_dec;
            res.data_byte      = item.byte_value;
            res.last_of_record = rec_last;
            if (rec_last) begin
              count_nxt = 2'd0;
              trail_nxt = '0;
            end
          end
        end
        PH_PAD: begin
          if (item.end_of_input) begin
            res_valid = 1'b1;
            res.kind  = KIND_TRUNC;
          end
        end
        PH_TRAILER: begin
          if (item.end_of_input) begin
            res_valid = 1'b1;
            res.kind  = KIND_TRUNC;
          end else begin
            trail_nxt = trail_acc;
            count_nxt = count_r + 2'd1;
            if (field_done) begin
              res_valid         = 1'b1;
              res.kind          = (trail_acc == leading_r) ? KIND_GOOD : KIND_MISMATCH;
              res.record_length = leading_r[LEN_W-1:0];
            end
          end
        end
        PH_HALTED: begin
          res_valid = 1'b0;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      count_r   <= 2'd0;
      leading_r <= '0;
      rem_r     <= '0;
      trail_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      leading_r <= leading_nxt;
      rem_r     <= rem_nxt;
      trail_r   <= trail_nxt;
    end
  end

  `TRD_ASSERT(a_halt_sticky, (phase_r == PH_HALTED) |=> (phase_r == PH_HALTED), "halted state left before reset")
  `TRD_ASSERT(a_payload_rem, (phase_r == PH_PAYLOAD) |-> (rem_r != '0), "payload phase with no bytes remaining")
  `TRD_ASSERT(a_data_in_payload, (res_valid && (res.kind == KIND_DATA)) |-> (phase_r == PH_PAYLOAD), "data beat produced outside payload")
  `TRD_ASSERT(a_count_clear, ((phase_r == PH_PAD) || (phase_r == PH_PAYLOAD)) |-> (count_r == 2'd0), "field byte count not cleared")

endmodule

`default_nettype wire

>>> rtl/trd_out_reg.sv
// ----------------------------------------------------------------------------
// trd_out_reg
// Result register toward the output channel; sets the parser advance.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  input  wire logic              res_valid,
  input  wire trd_pkg::result_t  res,
  output logic                   advance,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output trd_pkg::result_t       out_res
);
  import trd_pkg::*;

  logic    valid_r;
  result_t res_r;

  // The register can take a new result when empty or when its beat leaves now.
  assign advance = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= item_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

>>> rtl/tape_record_deframer.sv
// ----------------------------------------------------------------------------
// tape_record_deframer
// Splits a tape container byte stream into records, marks and status beats.
// ----------------------------------------------------------------------------
// Path: one input register, then the combinational parser, then one result
//   register; a stall on the output can hold a beat between them.
// Throughput: one input beat per cycle while the output does not stall; the
//   only loop is the framing state update in trd_parse.
// Reset: synchronous, active low; returns to header parsing, clears all
//   framing state and loads max_record_bytes with 1048576.
// ----------------------------------------------------------------------------
`default_nettype none

module tape_record_deframer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input stream
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        in_byte_value,
  input  wire logic                              in_end_of_input,
  // Result stream
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [2:0]                             out_kind,
  output logic [7:0]                             out_data_byte,
  output logic                                   out_last_of_record,
  output logic [trd_pkg::LEN_W-1:0]              out_record_length,
  // Configuration port
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [trd_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [trd_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [trd_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                   cfg_pready
);
  import trd_pkg::*;

  item_t            in_item;
  item_t            item;
  logic             item_valid;
  logic             advance;
  logic             res_valid;
  result_t          res;
  result_t          out_res;
  logic [LEN_W-1:0] max_bytes;

  assign in_item.byte_value   = in_byte_value;
  assign in_item.end_of_input = in_end_of_input;

  // The single register holding the record length limit. The user must see that it is only
  // written while the stream is idle, so the parser reads it directly; the block does not enforce it.
  trd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .max_bytes (max_bytes)
  );

  // The input register holds one beat; it stalls the input only when the
  // held beat cannot move on because the result register is blocked.
  trd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // The parser consumes the held beat whenever the result register can take
  // a beat, whether or not this byte produces a result. Pad bytes, header
  // bytes other than the last one of a mark, an end-of-medium or an over-long
  // header, trailer bytes before the last, and all after a halt are consumed silently.
  trd_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .max_bytes  (max_bytes),
    .res_valid  (res_valid),
    .res        (res)
  );

  // The result register lets the input side keep moving while a finished
  // result beat waits on a stalled consumer, up to one held beat.
  trd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_data_byte      = out_res.data_byte;
  assign out_last_of_record = out_res.last_of_record;
  assign out_record_length  = out_res.record_length;

endmodule

`default_nettype wire

>>> tb/tape_record_deframer_test.sv
// ----------------------------------------------------------------------------
// tape_record_deframer_test
// Self-checking bench for the tape record deframer. A short table of
// hand-built frames comes first, then random well-formed record streams
// under several length limits and flow-control patterns, and finally one
// stream-ending event (chosen at random) followed by beats that the halted
// block must swallow. Every result beat is checked field by field against
// an in-bench model of the framing state or, for typed rows, the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tape_record_deframer_test;
  import trd_pkg::*;

  localparam int unsigned          WATCHDOG_LIMIT = 2000;
  localparam int unsigned          PHASE_BEATS    = 110;
  localparam logic [LEN_W-1:0]     MAX_BYTES_TOP  = 25'd16777216;
  localparam logic [LEN_W-1:0]     MAX_BYTES_LOW  = 25'd1;
  localparam logic [CFG_ADDR_W-1:0] MAX_BYTES_ADDR = {REG_MAX_RECORD_BYTES, 2'b00};

  // Results that are typed straight into the directed table.
  localparam result_t NO_RESULT     = '0;
  localparam result_t WANT_MARK     = '{KIND_MARK, 8'h00, 1'b0, 25'd0};
  localparam result_t WANT_FF_LAST  = '{KIND_DATA, 8'hFF, 1'b1, 25'd0};
  localparam result_t WANT_GOOD_ONE = '{KIND_GOOD, 8'h00, 1'b0, 25'd1};
  localparam result_t WANT_GOOD_TWO = '{KIND_GOOD, 8'h00, 1'b0, 25'd2};

  // The one way the stream is ended at the close of the run. Any of these
  // halts the block for good, and reset is applied only once.
  typedef enum logic [2:0] {
    END_AT_HEADER,
    END_MID_HEADER,
    END_OF_MEDIUM_LENGTH,
    END_TOO_LONG,
    END_MISMATCH,
    END_IN_PAYLOAD,
    END_IN_PAD,
    END_IN_TRAILER
  } ending_t;

  typedef struct {
    logic [7:0] b;
    logic       eoi;
    logic       typed;
    result_t    want;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte_value   = 8'h00;
  logic                  in_end_of_input = 1'b0;

  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [2:0]            out_kind;
  logic [7:0]            out_data_byte;
  logic                  out_last_of_record;
  logic [LEN_W-1:0]      out_record_length;

  logic                  cfg_psel        = 1'b0;
  logic                  cfg_penable     = 1'b0;
  logic                  cfg_pwrite      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr       = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata      = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Bench copy of the framing state and of the length limit.
  phase_t                fr_phase;
  logic [1:0]            fr_count;
  logic [31:0]           fr_lead;
  logic [LEN_W-1:0]      fr_left;
  logic [31:0]           fr_trail;
  logic [LEN_W-1:0]      max_bytes;

  result_t               expected_beats [$];
  int unsigned           fault_count    = 0;
  int unsigned           result_count   = 0;
  int unsigned           beats_sent     = 0;
  int unsigned           idle_cycles    = 0;
  int unsigned           send_idle_pct  = 0;
  int unsigned           recv_stall_pct = 0;
  stim_row_t             directed_rows [24];

  tape_record_deframer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte_value      (in_byte_value),
    .in_end_of_input    (in_end_of_input),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_data_byte      (out_data_byte),
    .out_last_of_record (out_last_of_record),
    .out_record_length  (out_record_length),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always #5 clk = ~clk;

  task automatic note_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("%s", what);
  endtask

  // Advances the framing state by one input beat. Returns 1 when the beat
  // produces a result beat, which is then left in res.
  function automatic logic deframe_predict(input logic [7:0] b, input logic eoi,
                                           output result_t res);
    logic [31:0] lane;
    res  = NO_RESULT;
    lane = 32'(b) << (8 * fr_count);
    // Once halted, nothing but reset brings the block back.
    if (fr_phase == PH_HALTED) return 1'b0;
    if (fr_phase == PH_HEADER) begin
      // The stream ending anywhere in a header is plain end of medium.
      if (eoi) begin
        fr_phase = PH_HALTED;
        res.kind = KIND_EOM;
        return 1'b1;
      end
      fr_lead  = (fr_count == 2'd0) ? lane : (fr_lead | lane);
      fr_count = fr_count + 2'd1;
      if (fr_count != 2'd0) return 1'b0;
      if (fr_lead == EOM_MARK) begin
        fr_phase = PH_HALTED;
        res.kind = KIND_EOM;
        return 1'b1;
      end
      // A zero length is a tape mark; the next header follows directly.
      if (fr_lead == 32'd0) begin
        res.kind = KIND_MARK;
        return 1'b1;
      end
      if (fr_lead > 32'(max_bytes)) begin
        fr_phase = PH_HALTED;
        res.kind = KIND_LONG;
        return 1'b1;
      end
      fr_left  = fr_lead[LEN_W-1:0];
      fr_phase = PH_PAYLOAD;
      return 1'b0;
    end
    // Ending in payload, pad or trailer leaves the record truncated.
    if (eoi) begin
      fr_phase = PH_HALTED;
      res.kind = KIND_TRUNC;
      return 1'b1;
    end
    case (fr_phase)
      PH_PAYLOAD: begin
        if (fr_left != '0) fr_left = fr_left - 1'b1;
        res.kind           = KIND_DATA;
        res.data_byte      = b;
        res.last_of_record = (fr_left == '0);
        if (res.last_of_record) begin
          fr_count = 2'd0;
          fr_trail = 32'd0;
          fr_phase = fr_lead[0] ? PH_PAD : PH_TRAILER;
        end
        return 1'b1;
      end
      // The pad byte after an odd payload is dropped whatever its value.
      PH_PAD: begin
        fr_phase = PH_TRAILER;
        return 1'b0;
      end
      default: begin
        fr_trail = fr_trail | lane;
        fr_count = fr_count + 2'd1;
        if (fr_count != 2'd0) return 1'b0;
        res.record_length = fr_lead[LEN_W-1:0];
        if (fr_trail == fr_lead) begin
          fr_phase = PH_HEADER;
          res.kind = KIND_GOOD;
        end else begin
          fr_phase = PH_HALTED;
          res.kind = KIND_MISMATCH;
        end
        return 1'b1;
      end
    endcase
  endfunction

  // Offers one input beat, waits for it to be taken and files whatever it
  // produces. A typed row files its written-in result instead of the
  // predicted one, though the framing state still advances.
  task automatic send_beat(input logic [7:0] b, input logic eoi, input logic typed,
                           input result_t want);
    result_t pred;
    logic    produced;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_byte_value   <= b;
    in_end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    produced = deframe_predict(b, eoi, pred);
    if (typed) expected_beats.push_back(want);
    else if (produced) expected_beats.push_back(pred);
  endtask

  // Sends header, then optionally payload, pad and trailer. A cut of zero
  // or more stops after that many bytes and ends the stream there.
  task automatic send_frame(input logic [31:0] lead, input logic [31:0] trail,
                            input logic with_body, input int cut);
    logic [7:0] frame [$];
    int         stop;
    for (int i = 0; i < 4; i++) frame.push_back(lead[8*i +: 8]);
    if (with_body) begin
      for (int unsigned i = 0; i < lead; i++) frame.push_back(8'($urandom));
      if (lead[0]) frame.push_back(8'($urandom));
      for (int i = 0; i < 4; i++) frame.push_back(trail[8*i +: 8]);
    end
    stop = (cut < 0) ? frame.size() : cut;
    for (int i = 0; i < stop; i++) send_beat(frame[i], 1'b0, 1'b0, NO_RESULT);
    if (cut >= 0) send_beat(8'($urandom), 1'b1, 1'b0, NO_RESULT);
  endtask

  // Mostly short records so the run stays quick; now and then a longer
  // one, and sometimes exactly the cap, which is the limit when that is lower.
  function automatic logic [31:0] pick_length();
    logic [31:0] cap;
    cap = (max_bytes < 64) ? 32'(max_bytes) : 32'd64;
    if ($urandom_range(19) == 0) cap = (max_bytes < 300) ? 32'(max_bytes) : 32'd300;
    if ($urandom_range(9) == 0) return cap;
    return $urandom_range(cap, 1);
  endfunction

  // Drops the input valid and waits until every filed result has come back,
  // then waits out anything still inside the pipeline.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_max_bytes(input logic [LEN_W-1:0] want);
    logic [CFG_DATA_W-1:0] rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= MAX_BYTES_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (rd != 32'(want))
      note_fault($sformatf("max_record_bytes read: expected %0d, got %0d", want, rd));
  endtask

  // APB write (setup, then access) followed by a read back of the register.
  task automatic write_max_bytes(input logic [LEN_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= MAX_BYTES_ADDR;
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    max_bytes    = value;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    check_max_bytes(value);
  endtask

  // Result side: compare each accepted beat with the oldest expectation and
  // pick the stall for the next cycle. Both use values from before the edge.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (expected_beats.size() == 0) begin
        note_fault($sformatf("result %0d: kind %0d byte %02h with nothing expected",
                             result_count, out_kind, out_data_byte));
      end else begin
        want = expected_beats.pop_front();
        if (out_kind != want.kind || out_data_byte != want.data_byte ||
            out_last_of_record != want.last_of_record ||
            out_record_length != want.record_length)
          note_fault($sformatf(
            "result %0d: expected kind %0d byte %02h last %0b len %0d, got %0d %02h %0b %0d",
            result_count, want.kind, want.data_byte, want.last_of_record,
            want.record_length, out_kind, out_data_byte, out_last_of_record,
            out_record_length));
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // A hung handshake on either side shows up as a long run of cycles with
  // no beat moving at all.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned phase_end;
    logic [31:0] len;
    ending_t     ending;

    fr_phase  = PH_HEADER;
    fr_count  = 2'd0;
    fr_lead   = 32'd0;
    fr_left   = '0;
    fr_trail  = 32'd0;
    max_bytes = MAX_BYTES_RESET;

    // A tape mark, then a one-byte record with its pad byte, then a
    // two-byte record. Both payload byte extremes appear.
    directed_rows = '{
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b1, WANT_MARK},
      '{8'h01, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b1, WANT_FF_LAST},
      '{8'hA5, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b1, WANT_GOOD_ONE},
      '{8'h02, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h7F, 1'b0, 1'b0, NO_RESULT},
      '{8'h02, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b1, WANT_GOOD_TWO}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_max_bytes(MAX_BYTES_RESET);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].b, directed_rows[i].eoi, directed_rows[i].typed,
                directed_rows[i].want);

    // Random record streams. The limit changes only between phases, when
    // every result is back, and every record respects the limit in force
    // so the block never halts before the very end.
    for (int p = 0; p < 8; p++) begin
      settle_block();
      case (p)
        0: write_max_bytes(MAX_BYTES_LOW);
        1: write_max_bytes(MAX_BYTES_TOP);
        2: write_max_bytes(LEN_W'($urandom_range(64, 2)));
        3: write_max_bytes(LEN_W'($urandom_range(32'(MAX_BYTES_TOP), 1)));
        4: write_max_bytes(MAX_BYTES_RESET);
        5: write_max_bytes(MAX_BYTES_LOW);
        6: write_max_bytes(LEN_W'($urandom_range(300, 2)));
        default: write_max_bytes(MAX_BYTES_TOP);
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) begin
        if ($urandom_range(7) == 0) begin
          send_frame(32'd0, 32'd0, 1'b0, -1);
        end else begin
          len = pick_length();
          send_frame(len, len, 1'b1, -1);
        end
      end
    end

    // One terminating event; the limit is at its top value here.
    ending = ending_t'($urandom_range(7));
    len    = pick_length();
    case (ending)
      END_AT_HEADER:        send_frame(32'd0, 32'd0, 1'b0, 0);
      END_MID_HEADER:       send_frame($urandom, 32'd0, 1'b0, $urandom_range(3, 1));
      END_OF_MEDIUM_LENGTH: send_frame(EOM_MARK, 32'd0, 1'b0, -1);
      END_TOO_LONG: begin
        if ($urandom_range(1) == 0) len = 32'(max_bytes) + 32'd1;
        else len = $urandom_range(32'hFFFF_FFFE, 32'(max_bytes) + 32'd1);
        send_frame(len, 32'd0, 1'b0, -1);
      end
      END_MISMATCH:   send_frame(len, len ^ (32'd1 << $urandom_range(31)), 1'b1, -1);
      END_IN_PAYLOAD: send_frame(len, len, 1'b1, 4 + int'($urandom_range(len - 1)));
      END_IN_PAD: begin
        len = len | 32'd1;
        send_frame(len, len, 1'b1, 4 + int'(len));
      end
      default: send_frame(len, len, 1'b1, 4 + int'(len) + int'(len[0]) +
                          int'($urandom_range(3)));
    endcase

    // The block is halted now; whatever follows must produce nothing.
    repeat (16) send_beat(8'($urandom), 1'($urandom), 1'b0, NO_RESULT);
    settle_block();

    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
